@@ hdl/b64uu_pkg.sv @@
`timescale 1ns / 1ps

package b64uu_pkg;

  // Width of the string length and position counters.
  localparam int unsigned LenBits = 16;
  // Width of the line count register.
  localparam int unsigned CountBits = 16;
  // Most characters that one input byte can cause.
  localparam int unsigned MaxChars = 6;
  localparam int unsigned CntBits = $clog2(MaxChars + 1);

  localparam logic [CountBits-1:0] DefaultPerLine = CountBits'(45);
  // Reciprocal of three, scaled by 2^17, for exact division of 16-bit values.
  localparam logic [16:0] Recip3 = 17'd43691;

  localparam logic [7:0] CharOffset = 8'h20;
  localparam logic [7:0] CharBackquote = 8'h60;
  localparam logic [7:0] CharPad = 8'h3D;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharPlus = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_UU_MODE     = 2'd0,
    CFG_COUNT_GIVEN = 2'd1,
    CFG_LINE_COUNT  = 2'd2
  } cfg_idx_e;

  // Characters caused by one input byte, in output order.
  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [CntBits-1:0]       cnt;
  } bundle_t;

  // Standard base64 alphabet.
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = CharUpperA + {2'b00, v};
    end else if (v < 6'd52) begin
      r = CharLowerA + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = CharZero + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = CharPlus;
    end else begin
      r = CharSlash;
    end
    return r;
  endfunction

  // Uuencode sextet: value plus space, with zero written as backquote.
  function automatic logic [7:0] uu_char(input logic [5:0] v);
    logic [7:0] r;
    if (v == 6'd0) begin
      r = CharBackquote;
    end else begin
      r = {2'b00, v} + CharOffset;
    end
    return r;
  endfunction

endpackage

@@ hdl/b64uu_core.sv @@
`timescale 1ns / 1ps

module b64uu_core
  import b64uu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [CountBits-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic [LenBits-1:0]   string_length_i,
  output logic                 bndl_valid_o,
  input  logic                 bndl_ready_i,
  output bundle_t              bndl_o
);

  logic                 uu_mode_q;
  logic                 count_given_q;
  logic [CountBits-1:0] line_count_q;
  logic [CountBits-1:0] per_q, per_d;

  logic                 s1_valid_q, s1_valid_d;
  logic [7:0]           s1_byte_q;
  logic [LenBits-1:0]   s1_len_q;

  logic [15:0]          held_q, held_d;
  logic [1:0]           fill_q, fill_d;
  logic [LenBits-1:0]   spos_q, spos_d;
  logic [15:0]          lpos_q, lpos_d;

  logic                 in_load;
  logic                 s1_go;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uu_mode_q     <= 1'b0;
      count_given_q <= 1'b0;
      line_count_q  <= DefaultPerLine;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_UU_MODE:     uu_mode_q <= cfg_data_i[0];
        CFG_COUNT_GIVEN: count_given_q <= cfg_data_i[0];
        CFG_LINE_COUNT:  line_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Bytes per line: the count rounded down to a multiple of three, at least three.
  logic [CountBits-1:0] req_count;
  logic [32:0]          div_prod;
  logic [15:0]          div_q;
  logic [17:0]          per_raw;

  always_comb begin
    req_count = count_given_q ? line_count_q : DefaultPerLine;
    div_prod  = 33'(req_count) * 33'(Recip3);
    div_q     = div_prod[32:17];
    per_raw   = {1'b0, div_q, 1'b0} + 18'(div_q);
    per_d     = (per_raw < 18'd3) ? CountBits'(3) : per_raw[CountBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_q <= DefaultPerLine;
    end else begin
      per_q <= per_d;
    end
  end

  // Input register.
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_load    = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      s1_byte_q <= data_byte_i;
      s1_len_q  <= string_length_i;
    end
  end

  // Encoding of the registered byte against the running string and line state.
  logic                 last_str;
  logic                 len_emit;
  logic [LenBits-1:0]   remain;
  logic [LenBits-1:0]   here;
  logic [2:0]           g;
  logic                 grp_done;
  logic [1:0]           grp_bytes;
  logic [7:0]           b0, b1, b2;
  logic [5:0]           v0, v1, v2, v3;
  logic [15:0]          lpos_add;
  logic                 nl_emit;
  logic [CntBits-1:0]   k;
  bundle_t              bndl;

  always_comb begin
    last_str = (s1_len_q <= spos_q) ||
               (({1'b0, spos_q} + (LenBits+1)'(1)) >= {1'b0, s1_len_q});
    len_emit = uu_mode_q && (lpos_q == 16'd0);
    remain   = (s1_len_q > spos_q) ? (s1_len_q - spos_q) : LenBits'(1);
    here     = (remain < LenBits'(per_q)) ? remain : LenBits'(per_q);

    g         = {1'b0, fill_q} + 3'd1;
    grp_done  = (g >= 3'd3) || last_str;
    grp_bytes = (g >= 3'd3) ? 2'd3 : g[1:0];

    if (g >= 3'd3) begin
      b0 = held_q[15:8];
      b1 = held_q[7:0];
      b2 = s1_byte_q;
    end else if (g == 3'd2) begin
      b0 = held_q[7:0];
      b1 = s1_byte_q;
      b2 = 8'd0;
    end else begin
      b0 = s1_byte_q;
      b1 = 8'd0;
      b2 = 8'd0;
    end
    v0 = b0[7:2];
    v1 = {b0[1:0], b1[7:4]};
    v2 = {b1[3:0], b2[7:6]};
    v3 = b2[5:0];

    lpos_add = lpos_q + 16'(grp_bytes);
    nl_emit  = grp_done && ((lpos_add >= per_q) || last_str);

    // Assemble the characters in output order.
    bndl.chars = '0;
    k = '0;
    if (len_emit) begin
      bndl.chars[k] = here[7:0] + CharOffset;
      k = k + CntBits'(1);
    end
    if (grp_done) begin
      if (uu_mode_q) begin
        bndl.chars[k]                 = uu_char(v0);
        bndl.chars[k + CntBits'(1)]   = uu_char(v1);
        bndl.chars[k + CntBits'(2)]   = uu_char(v2);
        bndl.chars[k + CntBits'(3)]   = uu_char(v3);
      end else begin
        bndl.chars[k]                 = b64_char(v0);
        bndl.chars[k + CntBits'(1)]   = b64_char(v1);
        bndl.chars[k + CntBits'(2)]   = (grp_bytes > 2'd1) ? b64_char(v2) : CharPad;
        bndl.chars[k + CntBits'(3)]   = (grp_bytes > 2'd2) ? b64_char(v3) : CharPad;
      end
      k = k + CntBits'(4);
      if (nl_emit) begin
        bndl.chars[k] = CharNewline;
        k = k + CntBits'(1);
      end
    end
    bndl.cnt = k;
  end

  assign bndl_o       = bndl;
  assign bndl_valid_o = s1_valid_q && (bndl.cnt != '0);
  assign s1_go        = s1_valid_q && ((bndl.cnt == '0) || bndl_ready_i);

  // Next string and line state.
  always_comb begin
    held_d = held_q;
    fill_d = fill_q;
    spos_d = spos_q;
    lpos_d = lpos_q;
    if (grp_done) begin
      held_d = '0;
      fill_d = '0;
      lpos_d = nl_emit ? 16'd0 : lpos_add;
    end else begin
      held_d = {held_q[7:0], s1_byte_q};
      fill_d = g[1:0];
    end
    if (last_str) begin
      spos_d = '0;
      lpos_d = '0;
      held_d = '0;
      fill_d = '0;
    end else begin
      spos_d = spos_q + LenBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      fill_q <= '0;
      spos_q <= '0;
      lpos_q <= '0;
    end else if (s1_go) begin
      held_q <= held_d;
      fill_q <= fill_d;
      spos_q <= spos_d;
      lpos_q <= lpos_d;
    end
  end

endmodule

@@ hdl/b64uu_serial.sv @@
`timescale 1ns / 1ps

module b64uu_serial
  import b64uu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       bndl_valid_i,
  output logic       bndl_ready_o,
  input  bundle_t    bndl_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       run_last_o
);

  bundle_t            bndl_q;
  logic               bfull_q, bfull_d;
  logic [CntBits-1:0] idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_char_q;
  logic               run_last_q;

  logic               out_free;
  logic               take_char;
  logic               last_char;
  logic               bndl_load;

  // One character moves into the output register per free cycle.
  assign out_free     = !out_valid_q || !out_stall_i;
  assign take_char    = bfull_q && out_free;
  assign last_char    = (idx_q == (bndl_q.cnt - CntBits'(1)));
  assign bndl_ready_o = !bfull_q || (take_char && last_char);
  assign bndl_load    = bndl_valid_i && bndl_ready_o;

  always_comb begin
    bfull_d     = bfull_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (take_char) begin
      out_valid_d = 1'b1;
      idx_d       = idx_q + CntBits'(1);
      if (last_char) begin
        bfull_d = 1'b0;
      end
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
    if (bndl_load) begin
      bfull_d = 1'b1;
      idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bfull_q     <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bfull_q     <= bfull_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Bundle and output payload registers.
  always_ff @(posedge clk_i) begin
    if (bndl_load) begin
      bndl_q <= bndl_i;
    end
    if (take_char) begin
      out_char_q <= bndl_q.chars[idx_q];
      run_last_q <= last_char;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign run_last_o  = run_last_q;

endmodule

@@ hdl/base64_uuencode_line_encoder.sv @@
`timescale 1ns / 1ps

// Channel  Handshake               Payload
// input    in_valid_i/in_stall_o   data_byte_i, string_length_i
// output   out_valid_o/out_stall_i out_char_o, run_last_o
// config   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A byte is registered, encoded combinationally into zero to six characters, and
// those characters leave one per unstalled cycle through the output register.
// A byte holds the input register until the character buffer takes its characters,
// or only until it is encoded when it causes none; its characters pass from the
// character buffer into the output register.
// The bytes-per-line value is registered again behind the configuration registers.
// Reset is asynchronous and clears all control state; there is no clearing pass.
// A stall on the output backs up through the character buffer to in_stall_o.

module base64_uuencode_line_encoder
  import b64uu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [CountBits-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic [LenBits-1:0]   string_length_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_char_o,
  output logic                 run_last_o
);

  logic    bndl_valid;
  logic    bndl_ready;
  bundle_t bndl;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  b64uu_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .string_length_i (string_length_i),
    .bndl_valid_o    (bndl_valid),
    .bndl_ready_i    (bndl_ready),
    .bndl_o          (bndl)
  );

  b64uu_serial u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bndl_valid_i (bndl_valid),
    .bndl_ready_o (bndl_ready),
    .bndl_i       (bndl),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .run_last_o   (run_last_o)
  );

endmodule

@@ bench/line_encoding_checker.sv @@
`timescale 1ns / 1ps

// Watches the configuration, byte and character channels of the line encoder.
// It keeps its own copy of the encoder state and predicts the characters of
// every accepted byte, then compares each character transfer in order.
module line_encoding_checker
  import b64uu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [CountBits-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [7:0]           data_byte_i,
  input  logic [LenBits-1:0]   string_length_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [7:0]           out_char_i,
  input  logic                 run_last_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_due_t;

  // Characters predicted but not yet seen on the output, oldest first.
  char_due_t chars_due[$];

  string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Shadow copy of the configuration registers.
  logic                 uu_mode_q     = 1'b0;
  logic                 count_given_q = 1'b0;
  logic [CountBits-1:0] line_count_q  = DefaultPerLine;

  // Shadow copy of the encoder state.
  logic [15:0]        held_q       = '0;
  logic [1:0]         fill_q       = '0;
  logic [LenBits-1:0] string_pos_q = '0;
  logic [15:0]        line_pos_q   = '0;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  // Bytes per line: the chosen count rounded down to a multiple of three, at least three.
  function automatic int unsigned bytes_per_line();
    int unsigned n;
    n = count_given_q ? int'(line_count_q) : int'(DefaultPerLine);
    n = (n / 3) * 3;
    if (n < 3) begin
      n = 3;
    end
    return n;
  endfunction

  // Works out the characters that one accepted byte causes and advances the state.
  function automatic void encode_byte(input logic [7:0] data, input logic [LenBits-1:0] len);
    int unsigned per;
    int unsigned pos;
    int unsigned g;
    int unsigned remain;
    int unsigned line_bytes;
    logic        last_of_string;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [5:0]  sx[4];
    logic [7:0]  chars[$];
    per = bytes_per_line();
    pos = string_pos_q;
    last_of_string = (len <= pos) || (pos + 1 >= len);

    // A uuencoded line opens with its byte count, taken from this byte's length.
    if (uu_mode_q && line_pos_q == 0) begin
      remain = (len > pos) ? len - pos : 1;
      line_bytes = (remain < per) ? remain : per;
      chars.push_back(8'(line_bytes + CharOffset));
    end

    g = fill_q + 1;
    if (g >= 3 || last_of_string) begin
      if (g >= 3) begin
        b0 = held_q[15:8];
        b1 = held_q[7:0];
        b2 = data;
        g = 3;
      end else if (g == 2) begin
        b0 = held_q[7:0];
        b1 = data;
        b2 = 8'h00;
      end else begin
        b0 = data;
        b1 = 8'h00;
        b2 = 8'h00;
      end
      sx[0] = b0[7:2];
      sx[1] = {b0[1:0], b1[7:4]};
      sx[2] = {b1[3:0], b2[7:6]};
      sx[3] = b2[5:0];
      for (int k = 0; k < 4; k++) begin
        if (uu_mode_q) begin
          chars.push_back(sx[k] == 6'd0 ? CharBackquote : {2'b00, sx[k]} + CharOffset);
        end else if (k > g) begin
          // Base64 pads the sextets that only hold missing bytes.
          chars.push_back(CharPad);
        end else begin
          chars.push_back(alphabet[sx[k]]);
        end
      end
      held_q = '0;
      fill_q = '0;
      line_pos_q = 16'(line_pos_q + g);
      if (line_pos_q >= per || last_of_string) begin
        chars.push_back(CharNewline);
        line_pos_q = '0;
      end
    end else begin
      held_q = {held_q[7:0], data};
      fill_q = 2'(g);
    end

    // The end of a string clears everything; otherwise count the byte.
    if (last_of_string) begin
      string_pos_q = '0;
      line_pos_q = '0;
      held_q = '0;
      fill_q = '0;
    end else begin
      string_pos_q = LenBits'(pos + 1);
    end

    foreach (chars[k]) begin
      chars_due.push_back(char_due_t'{chars[k], k == chars.size() - 1});
    end
  endfunction

  // Prints one line per mismatch; after a hundred the rest are only counted.
  task automatic report_mismatch(input string what);
    fail_count_o++;
    if (fail_count_o <= 100) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    char_due_t due;
    if (!rst_ni) begin
      uu_mode_q = 1'b0;
      count_given_q = 1'b0;
      line_count_q = DefaultPerLine;
      held_q = '0;
      fill_q = '0;
      string_pos_q = '0;
      line_pos_q = '0;
      chars_due.delete();
      pending_o = 0;
    end else begin
      // A character transfer only ever drains characters of earlier bytes.
      if (out_valid_i && !out_stall_i) begin
        if (chars_due.size() == 0) begin
          report_mismatch($sformatf("character %h arrived with none expected", out_char_i));
        end else begin
          due = chars_due.pop_front();
          if (out_char_i !== due.ch) begin
            report_mismatch($sformatf("out_char %h, expected %h", out_char_i, due.ch));
          end
          if (run_last_i !== due.last) begin
            report_mismatch($sformatf("run_last %b, expected %b on character %h",
                                      run_last_i, due.last, due.ch));
          end
        end
      end

      // Register writes take effect for the next byte.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_UU_MODE: begin
            uu_mode_q = cfg_data_i[0];
          end
          CFG_COUNT_GIVEN: begin
            count_given_q = cfg_data_i[0];
          end
          CFG_LINE_COUNT: begin
            line_count_q = cfg_data_i;
          end
          default: begin
          end
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        encode_byte(data_byte_i, string_length_i);
      end
      pending_o = chars_due.size();
    end
  end

endmodule

@@ bench/base64_uuencode_line_encoder_test.sv @@
`timescale 1ns / 1ps

// Drives strings of bytes and register settings into the line encoder under
// several idling patterns; the checker beside the block does the comparing.
module base64_uuencode_line_encoder_test;
  import b64uu_pkg::*;

  // Cycles allowed for a byte that causes no character to leave the block.
  localparam int SettleCycles = 20;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [1:0]           cfg_index_i = CFG_UU_MODE;
  logic [CountBits-1:0] cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           data_byte_i = '0;
  logic [LenBits-1:0]   string_length_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [7:0]           out_char_o;
  logic                 run_last_o;

  int unsigned fail_count;
  int unsigned chars_pending;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  base64_uuencode_line_encoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .string_length_i(string_length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_char_o     (out_char_o),
    .run_last_o     (run_last_o)
  );

  line_encoding_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .string_length_i(string_length_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_char_i     (out_char_o),
    .run_last_i     (run_last_o),
    .fail_count_o   (fail_count),
    .pending_o      (chars_pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Random back pressure on the character channel.
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Offers one byte after a random gap and returns at the falling edge after its transfer.
  task automatic push_byte(input logic [7:0] data, input logic [LenBits-1:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= data;
    string_length_i <= len;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic push_random_bytes(input int unsigned n, input logic [LenBits-1:0] len);
    for (int unsigned i = 0; i < n; i++) begin
      push_byte(8'($urandom_range(255)), len);
    end
  endtask

  // Lets every expected character drain, then the last byte settle.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (chars_pending != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CountBits-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic uu, input logic given, input logic [CountBits-1:0] count);
    wait_quiet();
    write_reg(CFG_UU_MODE, CountBits'(uu));
    write_reg(CFG_COUNT_GIVEN, CountBits'(given));
    write_reg(CFG_LINE_COUNT, count);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      1: begin
        send_idle_pct = 51;
        stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct = 51;
      end
      default: begin
        send_idle_pct = 30;
        stall_pct = 30;
      end
    endcase
  endtask

  // Mostly short strings, now and then a few lines' worth.
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) begin
      return $urandom_range(1, 12);
    end else if (r < 95) begin
      return $urandom_range(13, 60);
    end
    return $urandom_range(61, 140);
  endfunction

  function automatic logic [CountBits-1:0] pick_line_count();
    case ($urandom_range(7))
      0: return '0;
      1: return CountBits'($urandom_range(1, 2));
      2: return '1;
      3: return DefaultPerLine;
      default: return CountBits'($urandom_range(3, 30));
    endcase
  endfunction

  // Random traffic: mostly well-formed strings, the rest broken or noisy.
  task automatic random_phase(input int unsigned items);
    int unsigned sent;
    int unsigned n;
    int unsigned kind;
    int unsigned len;
    sent = 0;
    while (sent < items) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        n = pick_length();
        push_random_bytes(n, LenBits'(n));
      end else if (kind < 85) begin
        // The length promises more bytes than arrive; a short length ends the string.
        n = $urandom_range(1, 8);
        push_random_bytes(n, LenBits'($urandom_range(n + 1, 65535)));
        push_byte(8'($urandom_range(255)), LenBits'($urandom_range(1)));
        n++;
      end else if (kind < 93) begin
        // The length changes from byte to byte.
        n = $urandom_range(2, 8);
        for (int unsigned i = 0; i < n; i++) begin
          push_byte(8'($urandom_range(255)), LenBits'($urandom_range(1, 10)));
        end
      end else begin
        n = 1;
        case ($urandom_range(2))
          0: len = 0;
          1: len = 65535;
          default: len = $urandom_range(65535);
        endcase
        push_byte(8'($urandom_range(255)), LenBits'(len));
      end
      sent += n;
    end
    // Sometimes leave a string half done across the next register writes.
    if ($urandom_range(2) == 0) begin
      n = $urandom_range(1, 5);
      push_random_bytes(n, LenBits'(n + $urandom_range(1, 40)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: base64 with the default line length and extreme byte values.
    set_idling(0);
    push_byte(8'h00, 16'd1);
    push_byte(8'hFF, 16'd2);
    push_byte(8'hFF, 16'd2);
    push_byte(8'hFB, 16'd3);
    push_byte(8'hFF, 16'd3);
    push_byte(8'hBF, 16'd3);

    // Uuencode with the minimum line of three bytes, so several lines appear.
    configure(1'b1, 1'b1, '0);
    push_byte(8'h00, 16'd7);
    push_byte(8'hFF, 16'd7);
    push_byte(8'h10, 16'd7);
    push_byte(8'h20, 16'd7);
    push_byte(8'h30, 16'd7);
    push_byte(8'h40, 16'd7);
    push_byte(8'h00, 16'd7);
    // A zero length ends the string at once.
    push_byte(8'h41, 16'd0);
    // The length shrinks while the string is under way.
    push_byte(8'h12, 16'd5);
    push_byte(8'h34, 16'd5);
    push_byte(8'h56, 16'd2);

    // The longest line makes the length character wrap past eight bits.
    configure(1'b1, 1'b1, '1);
    push_byte(8'h7E, 16'hFFFF);
    push_byte(8'h81, 16'd1);

    // Random phases, cycling through the idling patterns.
    for (int unsigned p = 0; p < 16; p++) begin
      case (p)
        0: configure(1'b0, 1'b1, '0);
        1: configure(1'b1, 1'b1, '1);
        2: configure(1'b1, 1'b0, 16'd1);
        3: configure(1'b0, 1'b1, 16'd2);
        default: configure(1'($urandom_range(1)), $urandom_range(3) != 0, pick_line_count());
      endcase
      set_idling(p % 4);
      random_phase(10);
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/b64uu_pkg.sv
hdl/b64uu_core.sv
hdl/b64uu_serial.sv
hdl/base64_uuencode_line_encoder.sv
bench/line_encoding_checker.sv
bench/base64_uuencode_line_encoder_test.sv
